[design/aabb_affine_transform_defines.svh]
// Assertion macros used by the checker file of the box transform.
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define AAT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication delayed by the n argument, sampled on clk, quiet while rst_n is low.
`define AAT_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

[design/aat_pkg.sv]
// Shared constants, types and register codes of the box transform.
package aat_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int COEF_WIDTH     = 16;
    localparam int COORD_FRAC     = 8;
    localparam int COEF_FRAC      = 12;
    localparam int LANE_BITS      = 16;
    localparam int NUM_LANES      = 4;
    localparam int ROW_WIDTH      = LANE_BITS * NUM_LANES;
    localparam int NUM_AXES       = 3;
    localparam int NUM_REGS       = 3;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int PROD_WIDTH     = COORD_WIDTH + COEF_WIDTH;
    localparam int TRANS_WIDTH    = COEF_WIDTH + COORD_FRAC;
    localparam int ACC_WIDTH      = PROD_WIDTH + 2;
    localparam int RND_WIDTH      = ACC_WIDTH - COEF_FRAC;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_WIDTH = FIFO_PTR_WIDTH + 1;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_X = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_Y = CFG_IDX_WIDTH'(1);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_Z = CFG_IDX_WIDTH'(2);

    // identity matrix rows, zero translation
    localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = ROW_WIDTH'(1) << COEF_FRAC;
    localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = ROW_WIDTH'(1) << (COEF_FRAC + LANE_BITS);
    localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET =
        ROW_WIDTH'(1) << (COEF_FRAC + 2 * LANE_BITS);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [TRANS_WIDTH-1:0] trans_t;

    // per-term extremes of one box: [axis][column]
    typedef struct packed {
        prod_t [NUM_AXES-1:0][NUM_AXES-1:0] lo;
        prod_t [NUM_AXES-1:0][NUM_AXES-1:0] hi;
        trans_t [NUM_AXES-1:0]              trans;
    } term_t;

    typedef struct packed {
        logic  push;
        term_t term;
    } push_t;

    typedef struct packed {
        logic  valid;
        term_t term;
    } pop_t;

endpackage

[design/aabb_affine_transform.sv]
// An accepted box passes corner, product, queue, read and result registers before done.
// Throughput: one box per cycle; every multiply, compare and sum has a pipeline stage
// of its own and the back part drains the queue every cycle, so busy stays low.
// Reset: rst_n clears all valid and queue state and loads the identity matrix with
// zero translation into the three coefficient rows.
module aabb_affine_transform (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_wr_en,
    input  logic [aat_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [aat_pkg::ROW_WIDTH-1:0]     cfg_data,
    input  aat_pkg::coord_t                   in_min_x,
    input  aat_pkg::coord_t                   in_min_y,
    input  aat_pkg::coord_t                   in_min_z,
    input  aat_pkg::coord_t                   in_max_x,
    input  aat_pkg::coord_t                   in_max_y,
    input  aat_pkg::coord_t                   in_max_z,
    output logic                              done,
    output aat_pkg::coord_t                   out_min_x,
    output aat_pkg::coord_t                   out_min_y,
    output aat_pkg::coord_t                   out_min_z,
    output aat_pkg::coord_t                   out_max_x,
    output aat_pkg::coord_t                   out_max_y,
    output aat_pkg::coord_t                   out_max_z
);
    import aat_pkg::*;

    // Pipeline:
    //   edge 0  capture box corners (front)
    //   edge 1  18 products, coefficient x coordinate, plus translation terms
    //   edge 2  per-term min/max picked and written to the queue as one word
    //   edge 3  queue read register (back)
    //   edge 4  sum, round half up, saturate, register result box
    push_t                     wr;
    pop_t                      rd;
    logic [FIFO_LVL_WIDTH-1:0] fifo_level;

    aat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_min_x   (in_min_x),
        .in_min_y   (in_min_y),
        .in_min_z   (in_min_z),
        .in_max_x   (in_max_x),
        .in_max_y   (in_max_y),
        .in_max_z   (in_max_z),
        .fifo_level (fifo_level),
        .wr         (wr)
    );

    // decouple classification from the summing stage
    aat_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .level (fifo_level)
    );

    aat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (rd),
        .done      (done),
        .out_min_x (out_min_x),
        .out_min_y (out_min_y),
        .out_min_z (out_min_z),
        .out_max_x (out_max_x),
        .out_max_y (out_max_y),
        .out_max_z (out_max_z)
    );

endmodule

[design/aat_fifo.sv]
// Short queue of classified terms between the front and back parts.
module aat_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  aat_pkg::push_t                     wr,
    output aat_pkg::pop_t                      rd,
    output logic [aat_pkg::FIFO_LVL_WIDTH-1:0] level
);
    import aat_pkg::*;

    term_t                     mem [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_WIDTH-1:0] level_reg, level_next;
    logic                      rd_vld_reg;
    term_t                     rd_data_reg;
    logic                      pop;

    // the back part never stalls: drain whenever a word is held
    assign pop = (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_WIDTH'(FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + FIFO_PTR_WIDTH'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_WIDTH'(FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + FIFO_PTR_WIDTH'(1);
        end
        level_next = level_reg + FIFO_LVL_WIDTH'(wr.push) - FIFO_LVL_WIDTH'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
            rd_vld_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem[wr_ptr_reg] <= wr.term;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd.valid = rd_vld_reg;
    assign rd.term  = rd_data_reg;
    assign level    = level_reg;

endmodule

[design/aat_front.sv]
// Front part: coefficient registers, input capture, products and per-term min/max.
module aat_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_wr_en,
    input  logic [aat_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [aat_pkg::ROW_WIDTH-1:0]     cfg_data,
    input  aat_pkg::coord_t                   in_min_x,
    input  aat_pkg::coord_t                   in_min_y,
    input  aat_pkg::coord_t                   in_min_z,
    input  aat_pkg::coord_t                   in_max_x,
    input  aat_pkg::coord_t                   in_max_y,
    input  aat_pkg::coord_t                   in_max_z,
    input  logic [aat_pkg::FIFO_LVL_WIDTH-1:0] fifo_level,
    output aat_pkg::push_t                    wr
);
    import aat_pkg::*;

    logic [ROW_WIDTH-1:0]      row_reg [NUM_REGS];
    logic                      in_vld_reg;
    logic                      prod_vld_reg;
    coord_t                    corner_reg [2][NUM_AXES];
    prod_t                     prod_reg [NUM_AXES][NUM_AXES][2];
    trans_t                    trans_reg [NUM_AXES];
    coef_t                     coef [NUM_AXES][NUM_LANES];
    logic [FIFO_LVL_WIDTH:0]   occupancy;
    logic                      accept;

    // hold off while queue words plus words in flight would fill the queue
    assign occupancy = {1'b0, fifo_level} + (FIFO_LVL_WIDTH + 1)'(in_vld_reg)
                     + (FIFO_LVL_WIDTH + 1)'(prod_vld_reg);
    assign busy      = (occupancy >= (FIFO_LVL_WIDTH + 1)'(FIFO_DEPTH));
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_X_RESET;
            row_reg[1] <= ROW_Y_RESET;
            row_reg[2] <= ROW_Z_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ROW_X: row_reg[0] <= cfg_data;
                REG_ROW_Y: row_reg[1] <= cfg_data;
                REG_ROW_Z: row_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // low COEF_WIDTH bits of each lane, sign-extended
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                coef[a][l] = $signed(row_reg[a][l * LANE_BITS +: COEF_WIDTH]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg   <= accept;
            prod_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            corner_reg[0][0] <= in_min_x;
            corner_reg[0][1] <= in_min_y;
            corner_reg[0][2] <= in_min_z;
            corner_reg[1][0] <= in_max_x;
            corner_reg[1][1] <= in_max_y;
            corner_reg[1][2] <= in_max_z;
        end
        if (in_vld_reg)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        prod_reg[a][j][s] <= prod_t'(coef[a][j]) * prod_t'(corner_reg[s][j]);
                    end
                end
                trans_reg[a] <= $signed({coef[a][NUM_LANES-1], COORD_FRAC'(0)});
            end
        end
    end

    // each term depends on one coordinate only: its extremes over the
    // eight corners come from min and max of that coordinate alone
    always_comb
    begin
        wr.push = prod_vld_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                if (prod_reg[a][j][0] < prod_reg[a][j][1])
                begin
                    wr.term.lo[a][j] = prod_reg[a][j][0];
                    wr.term.hi[a][j] = prod_reg[a][j][1];
                end
                else
                begin
                    wr.term.lo[a][j] = prod_reg[a][j][1];
                    wr.term.hi[a][j] = prod_reg[a][j][0];
                end
            end
            wr.term.trans[a] = trans_reg[a];
        end
    end

endmodule

[design/aat_back.sv]
// Back part: sum terms, round, saturate and register the result box.
module aat_back (
    input  logic            clk,
    input  logic            rst_n,
    input  aat_pkg::pop_t   rd,
    output logic            done,
    output aat_pkg::coord_t out_min_x,
    output aat_pkg::coord_t out_min_y,
    output aat_pkg::coord_t out_min_z,
    output aat_pkg::coord_t out_max_x,
    output aat_pkg::coord_t out_max_y,
    output aat_pkg::coord_t out_max_z
);
    import aat_pkg::*;

    localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'(1) << (COEF_FRAC - 1);
    localparam logic signed [RND_WIDTH-1:0] SAT_HI =
        {{(RND_WIDTH - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [RND_WIDTH-1:0] SAT_LO =
        {{(RND_WIDTH - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

    logic   done_reg;
    coord_t mn_reg [NUM_AXES];
    coord_t mx_reg [NUM_AXES];
    coord_t mn_next [NUM_AXES];
    coord_t mx_next [NUM_AXES];

    function automatic coord_t round_sat(input logic signed [ACC_WIDTH-1:0] acc);
        logic signed [ACC_WIDTH-1:0] biased;
        logic signed [RND_WIDTH-1:0] r;
        biased = acc + ROUND_BIAS;
        r      = $signed(biased[ACC_WIDTH-1:COEF_FRAC]);
        if (r > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (r < SAT_LO)
        begin
            r = SAT_LO;
        end
        return r[COORD_WIDTH-1:0];
    endfunction

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            mn_next[a] = round_sat(ACC_WIDTH'(rd.term.lo[a][0]) + ACC_WIDTH'(rd.term.lo[a][1])
                                 + ACC_WIDTH'(rd.term.lo[a][2])
                                 + ACC_WIDTH'(rd.term.trans[a]));
            mx_next[a] = round_sat(ACC_WIDTH'(rd.term.hi[a][0]) + ACC_WIDTH'(rd.term.hi[a][1])
                                 + ACC_WIDTH'(rd.term.hi[a][2])
                                 + ACC_WIDTH'(rd.term.trans[a]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.valid)
        begin
            mn_reg <= mn_next;
            mx_reg <= mx_next;
        end
    end

    assign done      = done_reg;
    assign out_min_x = mn_reg[0];
    assign out_min_y = mn_reg[1];
    assign out_min_z = mn_reg[2];
    assign out_max_x = mx_reg[0];
    assign out_max_y = mx_reg[1];
    assign out_max_z = mx_reg[2];

endmodule

[design/aat_checker.sv]
// Port-level checks of the box transform and their binding to the top level.
`include "aabb_affine_transform_defines.svh"

module aat_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input aat_pkg::coord_t out_min_x,
    input aat_pkg::coord_t out_min_y,
    input aat_pkg::coord_t out_min_z,
    input aat_pkg::coord_t out_max_x,
    input aat_pkg::coord_t out_max_y,
    input aat_pkg::coord_t out_max_z
);

    logic box_ordered;

    assign box_ordered = (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
                      && (out_min_z <= out_max_z);

    // every accepted box gives its word: done is raised once the box has passed
    // the corner, product, queue, read and result registers
    `AAT_ASSERT_DELAY(a_accept_gives_done, start && !busy, 5, done, "accepted box lost")

    // every word stems from an accepted box earlier in the pipeline
    `AAT_ASSERT_IMPLY(a_done_has_source, done, $past(start && !busy, 5), "unexpected word")

    // the enclosing box is always proper, even for an inverted input box
    `AAT_ASSERT_IMPLY(a_box_ordered, done, box_ordered, "result min above max")

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (.*);

[dv/tb.sv]
// Testbench for aabb_affine_transform: directed and random boxes checked against a local predictor.
module tb;

    import aat_pkg::*;

    // A box result shows up this many cycles after its word is taken.
    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_BOXES = 115;

    // The index field has room for one code past the last row; writes there are dropped.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = CFG_IDX_WIDTH'(3);

    localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // Lane codes used to build rows by hand.
    localparam logic [LANE_BITS-1:0] LANE_POS_MAX = 16'h7fff;
    localparam logic [LANE_BITS-1:0] LANE_NEG_MAX = 16'h8000;
    localparam logic [LANE_BITS-1:0] LANE_ONE     = 16'h1000;
    localparam logic [LANE_BITS-1:0] LANE_HALF    = 16'h0800;
    localparam logic [LANE_BITS-1:0] LANE_ZERO    = 16'h0000;

    // Row styles for the random phases.
    typedef enum int {ROW_FULL, ROW_SMALL, ROW_EXTREME} row_style_t;

    // One box: index 0..2 is x, y, z.
    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } box_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     cfg_wr_en;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [ROW_WIDTH-1:0]     cfg_data;
    coord_t                   in_min_x;
    coord_t                   in_min_y;
    coord_t                   in_min_z;
    coord_t                   in_max_x;
    coord_t                   in_max_y;
    coord_t                   in_max_z;
    logic                     done;
    coord_t                   out_min_x;
    coord_t                   out_min_y;
    coord_t                   out_min_z;
    coord_t                   out_max_x;
    coord_t                   out_max_y;
    coord_t                   out_max_z;

    // Local copy of the three coefficient rows, tracked from the write port.
    logic [ROW_WIDTH-1:0] coef_rows [NUM_REGS];

    // Predicted enclosing boxes, oldest first.
    box_t expected_boxes [$];

    int     fail_count;
    int     box_count;
    int     result_count;
    int     row_write_count;
    int     cycle_count;
    logic   gaps_on;

    string lo_names [3] = '{"out_min_x", "out_min_y", "out_min_z"};
    string hi_names [3] = '{"out_max_x", "out_max_y", "out_max_z"};

    aabb_affine_transform i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_min_x  (in_min_x),
        .in_min_y  (in_min_y),
        .in_min_z  (in_min_z),
        .in_max_x  (in_max_x),
        .in_max_y  (in_max_y),
        .in_max_z  (in_max_z),
        .done      (done),
        .out_min_x (out_min_x),
        .out_min_y (out_min_y),
        .out_min_z (out_min_z),
        .out_max_x (out_max_x),
        .out_max_y (out_max_y),
        .out_max_z (out_max_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // One output coordinate of one corner: exact sum with 20 fraction bits,
    // round half up to 8 fraction bits, then clamp to the coordinate range.
    function automatic longint row_value(logic [ROW_WIDTH-1:0] row,
                                         longint x, longint y, longint z);
        longint c [NUM_LANES];
        longint acc;
        longint r;
        for (int i = 0; i < NUM_LANES; i++)
            c[i] = longint'($signed(row[i*LANE_BITS +: LANE_BITS]));
        // w is 1.0, which is 256 in the coordinate format
        acc = c[0] * x + c[1] * y + c[2] * z + c[3] * (longint'(1) << COORD_FRAC);
        r = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (r > COORD_MAX)
            r = COORD_MAX;
        if (r < COORD_MIN)
            r = COORD_MIN;
        return r;
    endfunction

    // Send all eight corners through the rows and keep the per-axis extremes.
    // Corner k takes x, y, z from the max side where bits 0, 1, 2 of k are set.
    function automatic box_t transform_box(box_t b);
        box_t   res;
        longint x;
        longint y;
        longint z;
        longint r;
        longint lo_v [3];
        longint hi_v [3];
        for (int k = 0; k < 8; k++)
        begin
            x = $signed(k[0] ? b.hi[0] : b.lo[0]);
            y = $signed(k[1] ? b.hi[1] : b.lo[1]);
            z = $signed(k[2] ? b.hi[2] : b.lo[2]);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                r = row_value(coef_rows[a], x, y, z);
                if (k == 0 || r < lo_v[a])
                    lo_v[a] = r;
                if (k == 0 || r > hi_v[a])
                    hi_v[a] = r;
            end
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            res.lo[a] = coord_t'(lo_v[a]);
            res.hi[a] = coord_t'(hi_v[a]);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Tracking and checking, all at the rising edge
    // ------------------------------------------------------------------

    // Track row writes, predict every word taken, and compare every strobed
    // result against the oldest prediction. Inputs and outputs are sampled
    // before the edge updates them, so nothing here races the DUT.
    always @(posedge clk)
    begin
        box_t got;
        box_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ROW_X: coef_rows[0] = cfg_data;
                    REG_ROW_Y: coef_rows[1] = cfg_data;
                    REG_ROW_Z: coef_rows[2] = cfg_data;
                    default:   ; // unused index: drop the write
                endcase
            end
            if (start && !busy)
            begin
                got.lo = {in_min_z, in_min_y, in_min_x};
                got.hi = {in_max_z, in_max_y, in_max_x};
                expected_boxes.push_back(transform_box(got));
            end
            if (done)
            begin
                got.lo = {out_min_z, out_min_y, out_min_x};
                got.hi = {out_max_z, out_max_y, out_max_x};
                result_count++;
                if (expected_boxes.size() == 0)
                begin
                    $error("result strobed with no box outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        if (got.lo[a] !== want.lo[a])
                        begin
                            $error("%s: expected %0d, got %0d", lo_names[a],
                                   $signed(want.lo[a]), $signed(got.lo[a]));
                            fail_count++;
                        end
                        if (got.hi[a] !== want.hi[a])
                        begin
                            $error("%s: expected %0d, got %0d", hi_names[a],
                                   $signed(want.hi[a]), $signed(got.hi[a]));
                            fail_count++;
                        end
                    end
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic box_t make_box(longint lx, longint ly, longint lz,
                                      longint hx, longint hy, longint hz);
        box_t b;
        b.lo = {coord_t'(lz), coord_t'(ly), coord_t'(lx)};
        b.hi = {coord_t'(hz), coord_t'(hy), coord_t'(hx)};
        return b;
    endfunction

    function automatic logic [ROW_WIDTH-1:0] make_row(logic [LANE_BITS-1:0] c0,
                                                      logic [LANE_BITS-1:0] c1,
                                                      logic [LANE_BITS-1:0] c2,
                                                      logic [LANE_BITS-1:0] t);
        return {t, c2, c1, c0};
    endfunction

    // Gap after a word: mostly none or short, now and then long.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [ROW_WIDTH-1:0] rand_row(row_style_t style);
        logic [ROW_WIDTH-1:0]  row;
        logic [LANE_BITS-1:0]  picks [5];
        picks = '{LANE_POS_MAX, LANE_NEG_MAX, LANE_ZERO, LANE_ONE, -LANE_ONE};
        row = {$urandom, $urandom};
        for (int i = 0; i < NUM_LANES; i++)
        begin
            case (style)
                ROW_SMALL:
                    // coefficients within +-1.0, translation anywhere
                    if (i < NUM_LANES - 1)
                        row[i*LANE_BITS +: LANE_BITS] =
                            LANE_BITS'($urandom_range(0, 2 * LANE_ONE)) - LANE_ONE;
                ROW_EXTREME:
                    row[i*LANE_BITS +: LANE_BITS] = picks[$urandom_range(0, 4)];
                default: ;
            endcase
        end
        return row;
    endfunction

    // Mostly proper boxes with random content; some thin ones, some with
    // min above max, some built only from the range ends.
    function automatic box_t rand_box();
        box_t        b;
        int unsigned roll;
        longint      base;
        longint      top;
        coord_t      t;
        longint      ends [4];
        ends = '{COORD_MIN, COORD_MAX, 0, -1};
        roll = $urandom_range(0, 99);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            b.lo[a] = coord_t'($urandom);
            b.hi[a] = coord_t'($urandom);
            if (roll < 75)
            begin
                if (roll >= 55)
                begin
                    base = $signed(b.lo[a]);
                    top  = base + $urandom_range(0, 4096);
                    if (top > COORD_MAX)
                        top = COORD_MAX;
                    b.hi[a] = coord_t'(top);
                end
                if ($signed(b.lo[a]) > $signed(b.hi[a]))
                begin
                    t       = b.lo[a];
                    b.lo[a] = b.hi[a];
                    b.hi[a] = t;
                end
            end
            else if (roll < 90)
            begin
                // inverted on this axis
                if ($signed(b.lo[a]) < $signed(b.hi[a]))
                begin
                    t       = b.lo[a];
                    b.lo[a] = b.hi[a];
                    b.hi[a] = t;
                end
            end
            else
            begin
                b.lo[a] = coord_t'(ends[$urandom_range(0, 3)]);
                b.hi[a] = coord_t'(ends[$urandom_range(0, 3)]);
            end
        end
        return b;
    endfunction

    // Present one word, hold it until taken, then idle for a random gap.
    // Called at a rising edge; returns at a rising edge.
    task automatic send_box(box_t b);
        int gap;
        in_min_x <= b.lo[0];
        in_min_y <= b.lo[1];
        in_min_z <= b.lo[2];
        in_max_x <= b.hi[0];
        in_max_y <= b.hi[1];
        in_max_z <= b.hi[2];
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        box_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every predicted box has come back.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_row(logic [CFG_IDX_WIDTH-1:0] idx, logic [ROW_WIDTH-1:0] data);
        wait_quiet();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        row_write_count++;
    endtask

    task automatic write_matrix(logic [ROW_WIDTH-1:0] rx, logic [ROW_WIDTH-1:0] ry,
                                logic [ROW_WIDTH-1:0] rz);
        write_row(REG_ROW_X, rx);
        write_row(REG_ROW_Y, ry);
        write_row(REG_ROW_Z, rz);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the rows hold the identity with no translation.
    task automatic test_reset_identity();
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(-1, -256, 3, 255, 256, 7));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    endtask

    // A write to the unused index must leave the identity in place.
    task automatic test_unused_index();
        write_row(REG_UNUSED, '1);
        send_box(make_box(-1000, 2000, -3000, 4000, 5000, 6000));
        send_box(make_box(COORD_MIN, 0, -1, COORD_MAX, 1, 0));
    endtask

    // Largest coefficients of both signs drive every axis into saturation;
    // zero coefficients leave only the translation, at its extremes on x and y.
    task automatic test_extreme_rows();
        logic [ROW_WIDTH-1:0] pos_row;
        logic [ROW_WIDTH-1:0] neg_row;
        pos_row = make_row(LANE_POS_MAX, LANE_POS_MAX, LANE_POS_MAX, LANE_POS_MAX);
        neg_row = make_row(LANE_NEG_MAX, LANE_NEG_MAX, LANE_NEG_MAX, LANE_NEG_MAX);
        write_matrix(pos_row, pos_row, pos_row);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        write_matrix(neg_row, neg_row, neg_row);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        write_matrix(make_row(LANE_ZERO, LANE_ZERO, LANE_ZERO, LANE_POS_MAX),
                     make_row(LANE_ZERO, LANE_ZERO, LANE_ZERO, LANE_NEG_MAX),
                     make_row(LANE_ZERO, LANE_ZERO, LANE_ZERO, LANE_ZERO));
        send_box(make_box(COORD_MIN, -5, 77, COORD_MAX, 5, 99));
    endtask

    // Boxes with min above max on some axes still give a proper box.
    task automatic test_min_above_max();
        write_matrix(make_row(LANE_HALF, -16'h0c00, 16'h0400, 16'h1234),
                     make_row(-LANE_HALF, LANE_ONE, 16'h0200, -16'h0321),
                     make_row(16'h0100, -16'h0080, -LANE_ONE, LANE_ZERO));
        send_box(make_box(1000, 2000, 3000, -1000, -2000, -3000));
        send_box(make_box(COORD_MAX, 0, COORD_MAX, COORD_MIN, 10, COORD_MIN));
        send_box(make_box(5, -5, 5, 4, 5, -5));
        send_box(make_box(0, COORD_MAX, -1, -1, COORD_MIN, 0));
    endtask

    // Half-way sums must round up: 0.5 * +-1 and 0.5 * +-3 land on ties.
    task automatic test_round_ties();
        write_row(REG_ROW_X, make_row(LANE_HALF, LANE_ZERO, LANE_ZERO, LANE_ZERO));
        send_box(make_box(-1, 0, 0, 1, 0, 0));
        send_box(make_box(-3, 0, 0, 3, 0, 0));
    endtask

    // Random phases: new rows for each phase, then a stream of boxes with
    // gaps switched on and off in stretches.
    task automatic test_random_stream();
        int         stretch;
        row_style_t style [NUM_REGS];
        logic [ROW_WIDTH-1:0] rows [NUM_REGS];
        for (int p = 0; p < PHASES; p++)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:  style[r] = ROW_FULL;
                    5, 6, 7:        style[r] = ROW_EXTREME;
                    default:        style[r] = ROW_SMALL;
                endcase
                rows[r] = rand_row(style[r]);
            end
            write_matrix(rows[0], rows[1], rows[2]);
            stretch = 0;
            for (int n = 0; n < PHASE_BOXES; n++)
            begin
                if (stretch == 0)
                begin
                    gaps_on = ($urandom_range(0, 9) < 7);
                    stretch = $urandom_range(15, 40);
                end
                stretch--;
                send_box(rand_box());
            end
            gaps_on = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial
    begin
        fail_count      = 0;
        box_count       = 0;
        result_count    = 0;
        row_write_count = 0;
        cycle_count     = 0;
        gaps_on         = 1'b1;
        coef_rows[0]    = ROW_X_RESET;
        coef_rows[1]    = ROW_Y_RESET;
        coef_rows[2]    = ROW_Z_RESET;

        // Hold every input at a known value through reset.
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_ROW_X;
        cfg_data  <= '0;
        in_min_x  <= '0;
        in_min_y  <= '0;
        in_min_z  <= '0;
        in_max_x  <= '0;
        in_max_y  <= '0;
        in_max_z  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_identity();
        test_unused_index();
        test_extreme_rows();
        test_min_above_max();
        test_round_ties();
        test_random_stream();

        // Drain, then give the pipe a little longer to show any stray strobe.
        wait_quiet();
        repeat (2 * LATENCY) @(posedge clk);
        if (expected_boxes.size() != 0)
        begin
            $error("%0d boxes never came back", expected_boxes.size());
            fail_count++;
        end

        $display("Sent %0d boxes and checked %0d enclosing boxes over %0d row writes,",
                 box_count, result_count, row_write_count);
        $display("covering saturation, inverted boxes, rounding ties and the unused index.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
